>>> design/aals_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants for the anti-aliased line strip set-up block.
package aals_pkg;

  localparam int OFS_W  = 18;
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [11:0] K_TENTH    = 12'd410;
  localparam logic [11:0] K_SIXTENTH = 12'd2458;
  localparam logic [11:0] K_DIAG     = 12'd2896;
  localparam logic [14:0] CAP_OFS    = 15'd2458;

  typedef enum logic [1:0] {
    CFG_BLEND    = 2'd0,
    CFG_BG_RED   = 2'd1,
    CFG_BG_GREEN = 2'd2,
    CFG_BG_BLUE  = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic       blend;
    logic [7:0] bg_red_or_alpha;
    logic [7:0] bg_green;
    logic [7:0] bg_blue;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0]      x1;
    logic signed [15:0]      y1;
    logic signed [15:0]      x2;
    logic signed [15:0]      y2;
    logic signed [OFS_W-1:0] tx;
    logic signed [OFS_W-1:0] ty;
    logic signed [OFS_W-1:0] rx;
    logic signed [OFS_W-1:0] ry;
    logic signed [OFS_W-1:0] cx;
    logic signed [OFS_W-1:0] cy;
    logic [7:0]              er;
    logic [7:0]              eg;
    logic [7:0]              eb;
    logic [7:0]              ea;
    logic [7:0]              cr;
    logic [7:0]              cg;
    logic [7:0]              cb;
    logic [7:0]              ca;
    logic                    short_body;
    logic                    caps;
  } item_t;

endpackage
`default_nettype wire

>>> design/antialiased_line_strip_setup.sv
`timescale 1ns / 1ps
`default_nettype none
// Top level of the anti-aliased line strip set-up block.
//
// Input: a line is taken at a rising edge with start high and busy low:
// two Q12.4 endpoints, a Q4.4 width and an RGB colour.
// Output: 6, 8 or 16 strip vertices, one per cycle, each shown for one
// cycle with out_valid high; strip_id, strip_end and last mark the
// body strip, the two end caps and the final vertex of the line.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (blend mode, background red or alpha, background green, background blue)
// at once; write only while no line is in flight.
// Set-up: a line of width under 3 passes straight through the width, octant
// and offset states; a sloped line of width 3 or more runs the exact normal
// unit, a square root and then 6 divides, before it is queued.
// The back end emits one vertex a cycle, so narrow lines are paced by the
// back end; wide sloped lines are paced by the normal unit.
// A two-beat queue between set-up and emission lets the front work on the
// next line while the back is still emitting.
// Reset clears the configuration registers, the queue and both sequencers.
// The receiver cannot stall: every vertex is shown exactly once.
module antialiased_line_strip_setup (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                start,
  output logic               busy,
  input  wire signed [15:0]  in_start_x,
  input  wire signed [15:0]  in_start_y,
  input  wire signed [15:0]  in_end_x,
  input  wire signed [15:0]  in_end_y,
  input  wire [7:0]          in_line_width,
  input  wire [7:0]          in_line_red,
  input  wire [7:0]          in_line_green,
  input  wire [7:0]          in_line_blue,
  input  wire                cfg_we,
  input  wire [1:0]          cfg_index,
  input  wire [7:0]          cfg_data,
  output logic               out_valid,
  output logic signed [15:0] out_vertex_x,
  output logic signed [15:0] out_vertex_y,
  output logic [7:0]         out_red,
  output logic [7:0]         out_green,
  output logic [7:0]         out_blue,
  output logic [7:0]         out_alpha,
  output logic [1:0]         out_strip_id,
  output logic               out_strip_end,
  output logic               out_last
);

  aals_pkg::cfg_t   cfg_r;
  aals_pkg::item_t  q_in, q_out;
  logic             q_push, q_full, q_pop, q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (aals_pkg::cfg_idx_t'(cfg_index))
        aals_pkg::CFG_BLEND:    cfg_r.blend           <= cfg_data[0];
        aals_pkg::CFG_BG_RED:   cfg_r.bg_red_or_alpha <= cfg_data;
        aals_pkg::CFG_BG_GREEN: cfg_r.bg_green        <= cfg_data;
        default:                cfg_r.bg_blue         <= cfg_data;
      endcase
    end
  end

  aals_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_start_x    (in_start_x),
    .in_start_y    (in_start_y),
    .in_end_x      (in_end_x),
    .in_end_y      (in_end_y),
    .in_line_width (in_line_width),
    .in_line_red   (in_line_red),
    .in_line_green (in_line_green),
    .in_line_blue  (in_line_blue),
    .cfg           (cfg_r),
    .push          (q_push),
    .item          (q_in),
    .full          (q_full)
  );

  aals_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .item_in  (q_in),
    .full     (q_full),
    .pop      (q_pop),
    .item_out (q_out),
    .empty    (q_empty)
  );

  aals_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .item          (q_out),
    .empty         (q_empty),
    .pop           (q_pop),
    .out_valid     (out_valid),
    .out_vertex_x  (out_vertex_x),
    .out_vertex_y  (out_vertex_y),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_alpha     (out_alpha),
    .out_strip_id  (out_strip_id),
    .out_strip_end (out_strip_end),
    .out_last      (out_last)
  );

endmodule
`default_nettype wire

>>> design/aals_front.sv
`timescale 1ns / 1ps
`default_nettype none
// Front end: width rules, colours, offset selection and exact normal unit.
module aals_front (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  output logic                busy,
  input  wire signed [15:0]   in_start_x,
  input  wire signed [15:0]   in_start_y,
  input  wire signed [15:0]   in_end_x,
  input  wire signed [15:0]   in_end_y,
  input  wire [7:0]           in_line_width,
  input  wire [7:0]           in_line_red,
  input  wire [7:0]           in_line_green,
  input  wire [7:0]           in_line_blue,
  input  aals_pkg::cfg_t      cfg,
  output logic                push,
  output aals_pkg::item_t     item,
  input  wire                 full
);

  typedef enum logic [3:0] {
    S_IDLE, S_CLS, S_OCT, S_OFS, S_SQX, S_SQY, S_ROOT, S_MUL, S_DIV, S_PUSH
  } state_t;

  typedef enum logic [2:0] {
    OCT_FLAT, OCT_RISE, OCT_STEEP, OCT_FALL, OCT_NONE
  } oct_t;

  localparam int OW = aals_pkg::OFS_W;

  state_t                state_r;
  oct_t                  oct_r;
  aals_pkg::item_t       item_r;
  logic [7:0]            lw_r, lr_r, lg_r, lb_r;
  logic [14:0]           t_r;
  logic [12:0]           rr_r;
  logic signed [16:0]    dx_r, nx_r;
  logic                  vert_r;
  logic [14:0]           t10_r, td_r, r6_r, rd_r;
  logic [49:0]           v_r, res_r, bit_r;
  logic [32:0]           acc_r;
  logic [24:0]           lq_r;
  logic [2:0]            op_r;
  logic [3:0]            dcnt_r;
  logic [24:0]           rem_r;
  logic [15:0]           nlo_r, quo_r;
  logic                  neg_r;

  logic [3:0]            ip, q;
  logic [14:0]           q15, t_nxt;
  logic [12:0]           q13, r_nxt;
  logic [8:0]            q9, boost, sr, sg, sb;
  logic [11:0]           athin;
  logic [7:0]            br, bgc, bb, acore;
  logic signed [16:0]    dx_nxt, nx_nxt;
  logic                  axis_nxt, wide_nxt;
  logic signed [17:0]    ax, ay;
  logic signed [33:0]    dd, lo, hi;
  oct_t                  oct_nxt;
  logic [24:0]           m_t10, m_td, m_r6, m_rd;
  logic [14:0]           ts;
  logic [15:0]           anx, any;
  logic [49:0]           trial_s;
  logic                  ge_s;
  logic [49:0]           res_nxt;
  logic [14:0]           kmul;
  logic signed [16:0]    nsel;
  logic [15:0]           nmag;
  logic [30:0]           prod;
  logic [39:0]           num;
  logic [25:0]           trial_d;
  logic                  ge_d;
  logic [25:0]           rem_d;
  logic [15:0]           quo_nxt;
  logic signed [OW-1:0]  qval;

  function automatic logic signed [OW-1:0] ext(input logic [14:0] v);
    ext = $signed({{(OW-15){1'b0}}, v});
  endfunction

  assign busy = (state_r != S_IDLE);
  assign push = (state_r == S_PUSH) && !full;
  assign item = item_r;

  always_comb begin
    ip  = lw_r[7:4];
    q   = lw_r[3:0];
    q15 = 15'(q);
    q13 = 13'(q);
    unique case (ip)
      4'd0:    t_nxt = 15'd205;
      4'd1:    t_nxt = 15'd205 + 15'd84 * q15;
      4'd2:    t_nxt = 15'd1556 + 15'd148 * q15;
      4'd3:    t_nxt = 15'd3932 + 15'd123 * q15;
      4'd4:    t_nxt = 15'd5898 + 15'd118 * q15;
      4'd5:    t_nxt = 15'd7782 + 15'd154 * q15;
      default: t_nxt = {lw_r, 7'd0} - 15'd2048;
    endcase
    unique case (ip)
      4'd0:    r_nxt = 13'd1966 + 13'd82 * q13;
      4'd1:    r_nxt = 13'd3146 + 13'd80 * q13;
      default: r_nxt = 13'd4424;
    endcase
    q9    = 9'(q);
    boost = 9'd224 - 9'd14 * q9;
    sr    = 9'(lr_r) + boost;
    sg    = 9'(lg_r) + boost;
    sb    = 9'(lb_r) + boost;
    athin = 12'(cfg.bg_red_or_alpha) * 12'(q) + 12'd8;
    if (ip == 4'd0 && !cfg.blend) begin
      br  = sr[8] ? 8'd255 : sr[7:0];
      bgc = sg[8] ? 8'd255 : sg[7:0];
      bb  = sb[8] ? 8'd255 : sb[7:0];
    end else begin
      br  = lr_r;
      bgc = lg_r;
      bb  = lb_r;
    end
    acore    = (ip == 4'd0) ? athin[11:4] : cfg.bg_red_or_alpha;
    dx_nxt   = 17'(item_r.x2) - 17'(item_r.x1);
    nx_nxt   = 17'(item_r.y1) - 17'(item_r.y2);
    axis_nxt = (item_r.x1 == item_r.x2) || (item_r.y1 == item_r.y2);
    wide_nxt = !axis_nxt && (lw_r >= 8'd48);

    ax = (dx_r < 0) ? -18'(dx_r) : 18'(dx_r);
    ay = (dx_r < 0) ? 18'(nx_r) : -18'(nx_r);
    dd = 34'(ay) * 34'sd10000;
    lo = 34'(ax) * 34'sd4142;
    hi = 34'(ax) * 34'sd24142;
    priority if (dd > -lo && dd <= lo)      oct_nxt = OCT_FLAT;
    else if (dd > lo && dd <= hi)           oct_nxt = OCT_RISE;
    else if (dd > hi || dd <= -hi)          oct_nxt = OCT_STEEP;
    else if (dd > -hi && dd < -lo)          oct_nxt = OCT_FALL;
    else                                    oct_nxt = OCT_NONE;
    m_t10 = 25'(t_r) * 25'(aals_pkg::K_TENTH) + 25'd2048;
    m_td  = 25'(t_r) * 25'(aals_pkg::K_DIAG) + 25'd2048;
    m_r6  = 25'(rr_r) * 25'(aals_pkg::K_SIXTENTH) + 25'd2048;
    m_rd  = 25'(rr_r) * 25'(aals_pkg::K_DIAG) + 25'd2048;

    if (lw_r > 8'd0 && lw_r < 8'd16) ts = {t_r[11:0], 3'd0};
    else if (lw_r == 8'd16)          ts = 15'(t_r * 15'd10);
    else                             ts = t_r;

    anx     = (nx_r < 0) ? 16'(-nx_r) : 16'(nx_r);
    any     = (dx_r < 0) ? 16'(-dx_r) : 16'(dx_r);
    trial_s = res_r + bit_r;
    ge_s    = (v_r >= trial_s);
    res_nxt = ge_s ? ((res_r >> 1) + bit_r) : (res_r >> 1);

    if (op_r < 3'd2)      kmul = t_r;
    else if (op_r < 3'd4) kmul = 15'(rr_r);
    else                  kmul = aals_pkg::CAP_OFS;
    nsel = (op_r == 3'd0 || op_r == 3'd2 || op_r == 3'd5) ? nx_r : dx_r;
    nmag = (nsel < 0) ? 16'(-nsel) : 16'(nsel);
    prod = 31'(kmul) * 31'(nmag);
    num  = {1'b0, prod, 8'd0} + 40'(lq_r >> 1);

    trial_d = {rem_r, nlo_r[15]};
    ge_d    = (trial_d >= 26'(lq_r));
    rem_d   = ge_d ? (trial_d - 26'(lq_r)) : trial_d;
    quo_nxt = {quo_r[14:0], ge_d};
    qval    = neg_r ? -$signed({{(OW-16){1'b0}}, quo_nxt})
                    : $signed({{(OW-16){1'b0}}, quo_nxt});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            item_r.x1 <= in_start_x;
            item_r.y1 <= in_start_y;
            item_r.x2 <= in_end_x;
            item_r.y2 <= in_end_y;
            lw_r      <= in_line_width;
            lr_r      <= in_line_red;
            lg_r      <= in_line_green;
            lb_r      <= in_line_blue;
            state_r   <= S_CLS;
          end
        end
        S_CLS: begin
          t_r    <= t_nxt;
          rr_r   <= r_nxt;
          dx_r   <= dx_nxt;
          nx_r   <= nx_nxt;
          vert_r <= (item_r.x1 == item_r.x2);
          item_r.short_body <= axis_nxt && (lw_r <= 8'd16);
          item_r.caps       <= (lw_r >= 8'd48);
          item_r.cr <= br;
          item_r.cg <= bgc;
          item_r.cb <= bb;
          if (cfg.blend) begin
            item_r.er <= br;
            item_r.eg <= bgc;
            item_r.eb <= bb;
            item_r.ea <= 8'd0;
            item_r.ca <= acore;
          end else begin
            item_r.er <= cfg.bg_red_or_alpha;
            item_r.eg <= cfg.bg_green;
            item_r.eb <= cfg.bg_blue;
            item_r.ea <= 8'd255;
            item_r.ca <= 8'd255;
          end
          item_r.cx <= '0;
          item_r.cy <= '0;
          if (axis_nxt) begin
            oct_r <= OCT_NONE;
          end
          state_r <= wide_nxt ? S_SQX : S_OCT;
        end
        S_OCT: begin
          oct_r   <= oct_nxt;
          t10_r   <= 15'(m_t10[24:12]);
          td_r    <= 15'(m_td[24:12]);
          r6_r    <= 15'(m_r6[24:12]);
          rd_r    <= 15'(m_rd[24:12]);
          state_r <= S_OFS;
        end
        S_OFS: begin
          if (item_r.short_body || (item_r.x1 == item_r.x2)
              || (item_r.y1 == item_r.y2)) begin
            item_r.tx <= vert_r ? ext(ts) : '0;
            item_r.rx <= vert_r ? ext(15'(rr_r)) : '0;
            item_r.ty <= vert_r ? '0 : ext(ts);
            item_r.ry <= vert_r ? '0 : ext(15'(rr_r));
          end else begin
            unique case (oct_r)
              OCT_FLAT: begin
                item_r.tx <= ext(t10_r);
                item_r.ty <= ext(t_r);
                item_r.rx <= ext(r6_r);
                item_r.ry <= ext(15'(rr_r));
              end
              OCT_RISE: begin
                item_r.tx <= -ext(td_r);
                item_r.ty <= ext(td_r);
                item_r.rx <= -ext(rd_r);
                item_r.ry <= ext(rd_r);
              end
              OCT_STEEP: begin
                item_r.tx <= ext(t_r);
                item_r.ty <= ext(t10_r);
                item_r.rx <= ext(15'(rr_r));
                item_r.ry <= ext(r6_r);
              end
              OCT_FALL: begin
                item_r.tx <= ext(td_r);
                item_r.ty <= ext(td_r);
                item_r.rx <= ext(rd_r);
                item_r.ry <= ext(rd_r);
              end
              default: begin
                item_r.tx <= '0;
                item_r.ty <= '0;
                item_r.rx <= '0;
                item_r.ry <= '0;
              end
            endcase
          end
          state_r <= S_PUSH;
        end
        S_SQX: begin
          acc_r   <= 33'(32'(anx) * 32'(anx));
          state_r <= S_SQY;
        end
        S_SQY: begin
          v_r     <= {1'b0, acc_r + 33'(32'(any) * 32'(any)), 16'd0};
          res_r   <= '0;
          bit_r   <= 50'd1 << 48;
          state_r <= S_ROOT;
        end
        S_ROOT: begin
          if (ge_s) begin
            v_r <= v_r - trial_s;
          end
          res_r <= res_nxt;
          bit_r <= bit_r >> 2;
          if (bit_r[0]) begin
            lq_r    <= (res_nxt[24:0] == '0) ? 25'd1 : res_nxt[24:0];
            op_r    <= '0;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          rem_r   <= num[39:15] >> 1;
          nlo_r   <= num[15:0];
          quo_r   <= '0;
          neg_r   <= (nsel < 0) ^ (op_r == 3'd4);
          dcnt_r  <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          rem_r  <= rem_d[24:0];
          nlo_r  <= {nlo_r[14:0], 1'b0};
          quo_r  <= quo_nxt;
          dcnt_r <= dcnt_r + 4'd1;
          if (dcnt_r == 4'd15) begin
            unique case (op_r)
              3'd0:    item_r.tx <= qval;
              3'd1:    item_r.ty <= qval;
              3'd2:    item_r.rx <= qval;
              3'd3:    item_r.ry <= qval;
              3'd4:    item_r.cx <= qval;
              default: item_r.cy <= qval;
            endcase
            op_r    <= op_r + 3'd1;
            state_r <= (op_r == 3'd5) ? S_PUSH : S_MUL;
          end
        end
        S_PUSH: begin
          if (!full) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> design/aals_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// Short queue of set-up lines between front and back.
module aals_queue (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              push,
  input  aals_pkg::item_t  item_in,
  output logic             full,
  input  wire              pop,
  output aals_pkg::item_t  item_out,
  output logic             empty
);

  aals_pkg::item_t                 mem_r [aals_pkg::QDEPTH];
  logic [aals_pkg::QPTR_W-1:0]     wptr_r, rptr_r;
  logic [aals_pkg::QCNT_W-1:0]     cnt_r;

  assign full     = (cnt_r == aals_pkg::QCNT_W'(aals_pkg::QDEPTH));
  assign empty    = (cnt_r == '0);
  assign item_out = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= (wptr_r == aals_pkg::QPTR_W'(aals_pkg::QDEPTH - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= (rptr_r == aals_pkg::QPTR_W'(aals_pkg::QDEPTH - 1)) ? '0 : rptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> design/aals_back.sv
`timescale 1ns / 1ps
`default_nettype none
// Back end: walks one queued line and emits its strip vertices, one a cycle.
module aals_back (
  input  wire                clk,
  input  wire                rst_n,
  input  aals_pkg::item_t    item,
  input  wire                empty,
  output logic               pop,
  output logic               out_valid,
  output logic signed [15:0] out_vertex_x,
  output logic signed [15:0] out_vertex_y,
  output logic [7:0]         out_red,
  output logic [7:0]         out_green,
  output logic [7:0]         out_blue,
  output logic [7:0]         out_alpha,
  output logic [1:0]         out_strip_id,
  output logic               out_strip_end,
  output logic               out_last
);

  typedef enum logic [1:0] {SG_ZERO, SG_POS, SG_NEG} sgn_t;

  localparam int OW = aals_pkg::OFS_W;

  logic [3:0]          k_r;
  logic                valid_r;
  logic signed [15:0]  vx_r, vy_r;
  logic [7:0]          r_r, g_r, b_r, a_r;
  logic [1:0]          sid_r;
  logic                send_r, last_r;

  logic [3:0]          nbody, total, j;
  logic                in_cap, e2, core, send, lst;
  logic [1:0]          sid;
  sgn_t                st, sr, sc;
  logic signed [15:0]  bx, by, vx, vy;

  function automatic logic signed [19:0] pick(input sgn_t s, input logic signed [OW-1:0] v);
    unique case (s)
      SG_POS:  pick = 20'(v);
      SG_NEG:  pick = -20'(v);
      default: pick = '0;
    endcase
  endfunction

  function automatic logic signed [15:0] place(input logic signed [15:0] base,
                                               input logic signed [19:0] ofs);
    logic signed [25:0] v;
    logic signed [17:0] s;
    v = $signed({{2{base[15]}}, base, 8'd0}) + 26'(ofs) + 26'sd128;
    s = 18'(v >>> 8);
    if (s > 18'sd32767)       place = 16'sh7fff;
    else if (s < -18'sd32768) place = 16'sh8000;
    else                      place = s[15:0];
  endfunction

  always_comb begin
    nbody  = item.short_body ? 4'd6 : 4'd8;
    total  = nbody + (item.caps ? 4'd8 : 4'd0);
    in_cap = (k_r >= nbody);
    j      = k_r - nbody;
    sc     = SG_ZERO;
    if (!in_cap) begin
      e2   = k_r[0];
      sid  = 2'd0;
      send = (k_r == nbody - 4'd1);
      core = (k_r[2:1] == 2'd1) || (k_r[2:1] == 2'd2);
      unique case (k_r[2:1])
        2'd0:    begin st = SG_NEG; sr = SG_NEG;  end
        2'd1:    begin st = SG_NEG; sr = SG_ZERO; end
        2'd2:    begin st = SG_POS; sr = SG_ZERO; end
        default: begin st = SG_POS; sr = SG_POS;  end
      endcase
    end else begin
      e2   = j[2];
      sid  = j[2] ? 2'd2 : 2'd1;
      send = (j[1:0] == 2'd3);
      core = j[1];
      unique case (j[1:0])
        2'd0:    begin st = SG_ZERO; sr = SG_NEG; sc = j[2] ? SG_NEG : SG_POS; end
        2'd1:    begin st = SG_ZERO; sr = SG_POS; sc = j[2] ? SG_NEG : SG_POS; end
        2'd2:    begin st = SG_NEG;  sr = SG_NEG; end
        default: begin st = SG_POS;  sr = SG_POS; end
      endcase
    end
    lst = (k_r == total - 4'd1);
    bx  = e2 ? item.x2 : item.x1;
    by  = e2 ? item.y2 : item.y1;
    vx  = place(bx, pick(st, item.tx) + pick(sr, item.rx) + pick(sc, item.cx));
    vy  = place(by, pick(st, item.ty) + pick(sr, item.ry) + pick(sc, item.cy));
  end

  assign pop           = !empty && lst;
  assign out_valid     = valid_r;
  assign out_vertex_x  = vx_r;
  assign out_vertex_y  = vy_r;
  assign out_red       = r_r;
  assign out_green     = g_r;
  assign out_blue      = b_r;
  assign out_alpha     = a_r;
  assign out_strip_id  = sid_r;
  assign out_strip_end = send_r;
  assign out_last      = last_r;

  always_ff @(posedge clk) begin
    vx_r   <= vx;
    vy_r   <= vy;
    r_r    <= core ? item.cr : item.er;
    g_r    <= core ? item.cg : item.eg;
    b_r    <= core ? item.cb : item.eb;
    a_r    <= core ? item.ca : item.ea;
    sid_r  <= sid;
    send_r <= send;
    last_r <= lst;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r     <= '0;
      valid_r <= 1'b0;
    end else begin
      valid_r <= !empty;
      if (!empty) begin
        k_r <= lst ? 4'd0 : k_r + 4'd1;
      end
    end
  end

endmodule
`default_nettype wire

>>> design/aals_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// Port checker for the line strip set-up block, bound to the top level.
module aals_checker (
  input wire       clk,
  input wire       rst_n,
  input wire       out_valid,
  input wire [1:0] out_strip_id,
  input wire       out_strip_end,
  input wire       out_last
);

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("beat shown straight after reset");

  a_strip_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_strip_id == 2'd0 || out_strip_id == 2'd1 || out_strip_id == 2'd2))
    else $error("strip id out of range");

  a_last_ends_strip: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_strip_end)
    else $error("last beat does not end a strip");

  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid)
    else $error("gap inside a line");

  a_strip_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_strip_end |=> out_strip_id == $past(out_strip_id))
    else $error("strip id changed inside a strip");

endmodule

bind antialiased_line_strip_setup aals_checker u_aals_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_strip_id  (out_strip_id),
  .out_strip_end (out_strip_end),
  .out_last      (out_last)
);
`default_nettype wire
